// File: src/torque_contact_motion_detector_unit_assert.svh
// Assertion macros used by the detector top-level RTL.
`ifndef TORQUE_CONTACT_MOTION_DETECTOR_UNIT_ASSERT_SVH
`define TORQUE_CONTACT_MOTION_DETECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TCMD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/tcmd_pkg.sv
package tcmd_pkg;

  localparam int WINDOW     = 20;
  localparam int SUM_W      = 16 + $clog2(WINDOW);
  localparam int DIFF_W     = SUM_W + 1;
  localparam int THR_W      = 15 + $clog2(WINDOW);
  localparam int SLOT_W     = $clog2(WINDOW);
  localparam int FILL_W     = $clog2(2 * WINDOW + 2);
  localparam int TSUM_W     = 18;
  localparam int PROD_W     = 35;
  localparam int GAIN_SHIFT = 15;
  localparam int Q_W        = PROD_W - GAIN_SHIFT;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Sum of the joint 1..3 gravity offsets in Q5.10, and the negated pitch gain in Q1.15.
  localparam logic signed [TSUM_W-1:0] GRAVITY_OFFSET = -18'sd323;
  localparam logic signed [16:0]       NEG_PITCH_GAIN = -17'sd32211;
  localparam logic signed [PROD_W-1:0] ROUND_POS      = PROD_W'(1 << (GAIN_SHIFT - 1));
  localparam logic signed [PROD_W-1:0] ROUND_NEG      = ROUND_POS - PROD_W'(1);

  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_BIAS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_BIAS        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_THRESHOLD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STEP      = 3'd4;

  localparam logic signed [15:0] PITCH_BIAS_RST      = 16'sd5120;
  localparam logic signed [15:0] YAW_BIAS_RST        = 16'sd0;
  localparam logic [14:0]        PITCH_THRESHOLD_RST = 15'd1331;
  localparam logic [14:0]        YAW_THRESHOLD_RST   = 15'd819;
  localparam logic [12:0]        SPEED_STEP_RST      = 13'd154;

  typedef struct packed {
    logic               from_arm;
    logic signed [15:0] torque_joint0;
    logic signed [15:0] torque_joint1;
    logic signed [15:0] torque_joint2;
    logic signed [15:0] torque_joint3;
  } in_item_t;

  typedef struct packed {
    logic signed [13:0] speed_forward;
    logic signed [15:0] speed_turn;
    logic               contact_pitch;
    logic               contact_yaw;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] pitch_force;
    logic signed [15:0] yaw_force;
  } force_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] pitch_sum;
    logic signed [SUM_W-1:0] yaw_sum;
  } sum_t;

  // Configuration as the decision stage uses it: bias and threshold already scaled by WINDOW.
  typedef struct packed {
    logic signed [SUM_W-1:0] pitch_bias_w;
    logic signed [SUM_W-1:0] yaw_bias_w;
    logic [THR_W-1:0]        pitch_thr_w;
    logic [THR_W-1:0]        yaw_thr_w;
    logic [12:0]             step;
    logic [14:0]             step3;
  } cfg_t;

  function automatic logic signed [SUM_W-1:0] scale_bias(input logic signed [15:0] b);
    logic signed [SUM_W-1:0] b_ext;
    b_ext = SUM_W'(b);
    return b_ext * SUM_W'(WINDOW);
  endfunction

  function automatic logic [THR_W-1:0] scale_thr(input logic [14:0] t);
    logic [THR_W-1:0] t_ext;
    t_ext = THR_W'(t);
    return t_ext * THR_W'(WINDOW);
  endfunction

  function automatic logic [14:0] triple_step(input logic [12:0] s);
    logic [14:0] s_ext;
    s_ext = 15'(s);
    return s_ext + (s_ext << 1);
  endfunction

  // Round to nearest with ties away from zero, then saturate to 16 bits.
  function automatic logic signed [15:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] biased;
    logic signed [Q_W-1:0]    q;
    biased = p + (p[PROD_W-1] ? ROUND_NEG : ROUND_POS);
    q = biased[PROD_W-1:GAIN_SHIFT];
    if (q > Q_W'(32767)) begin
      return 16'sh7fff;
    end else if (q < Q_W'(-32768)) begin
      return 16'sh8000;
    end else begin
      return q[15:0];
    end
  endfunction

endpackage

// File: src/tcmd_cfg.sv
module tcmd_cfg import tcmd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pitch_bias_w <= scale_bias(PITCH_BIAS_RST);
      cfg_r.yaw_bias_w   <= scale_bias(YAW_BIAS_RST);
      cfg_r.pitch_thr_w  <= scale_thr(PITCH_THRESHOLD_RST);
      cfg_r.yaw_thr_w    <= scale_thr(YAW_THRESHOLD_RST);
      cfg_r.step         <= SPEED_STEP_RST;
      cfg_r.step3        <= triple_step(SPEED_STEP_RST);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PITCH_BIAS:      cfg_r.pitch_bias_w <= scale_bias(cfg_wdata);
        CFG_YAW_BIAS:        cfg_r.yaw_bias_w   <= scale_bias(cfg_wdata);
        CFG_PITCH_THRESHOLD: cfg_r.pitch_thr_w  <= scale_thr(cfg_wdata[14:0]);
        CFG_YAW_THRESHOLD:   cfg_r.yaw_thr_w    <= scale_thr(cfg_wdata[14:0]);
        CFG_SPEED_STEP: begin
          cfg_r.step  <= cfg_wdata[12:0];
          cfg_r.step3 <= triple_step(cfg_wdata[12:0]);
        end
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: src/tcmd_force.sv
module tcmd_force import tcmd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     frc_valid,
  input  logic     frc_ready,
  output force_t   frc_data
);

  logic                      v1_r, v2_r, v3_r;
  logic                      rdy1, rdy2, rdy3;
  logic signed [15:0]        t0_r, t1_r, t2_r, t3_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [15:0]        yaw2_r;
  force_t                    frc_r;
  logic signed [TSUM_W-1:0]  tsum;
  logic signed [PROD_W-1:0]  prod;

  assign rdy3     = !v3_r || frc_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign tsum = TSUM_W'(t1_r) + TSUM_W'(t2_r) + TSUM_W'(t3_r) + GRAVITY_OFFSET;
  assign prod = PROD_W'(tsum) * PROD_W'(NEG_PITCH_GAIN);

  // Items that are not arm samples are taken and dropped here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid && in_data.from_arm;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      t0_r <= in_data.torque_joint0;
      t1_r <= in_data.torque_joint1;
      t2_r <= in_data.torque_joint2;
      t3_r <= in_data.torque_joint3;
    end
    if (rdy2) begin
      prod_r <= prod;
      yaw2_r <= t0_r;
    end
    if (rdy3) begin
      frc_r.pitch_force <= round_sat(prod_r);
      frc_r.yaw_force   <= yaw2_r;
    end
  end

  assign frc_valid = v3_r;
  assign frc_data  = frc_r;

endmodule

// File: src/tcmd_window.sv
module tcmd_window import tcmd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   frc_valid,
  output logic   frc_ready,
  input  force_t frc_data,
  output logic   sum_valid,
  input  logic   sum_ready,
  output sum_t   sum_data
);

  logic signed [15:0]      pwin_r [WINDOW];
  logic signed [15:0]      ywin_r [WINDOW];
  logic signed [SUM_W-1:0] psum_r, ysum_r;
  logic signed [SUM_W-1:0] psum_nxt, ysum_nxt;
  logic [SLOT_W-1:0]       slot_r;
  logic [FILL_W-1:0]       fill_r;
  logic                    v4_r;
  logic                    rdy4, take, slot_used;
  logic signed [15:0]      pold, yold;

  assign rdy4      = !v4_r || sum_ready;
  assign frc_ready = rdy4;
  assign take      = rdy4 && frc_valid;

  // A slot that was never written counts as zero in the running sums.
  assign slot_used = fill_r >= FILL_W'(WINDOW);
  assign pold      = slot_used ? pwin_r[slot_r] : 16'sd0;
  assign yold      = slot_used ? ywin_r[slot_r] : 16'sd0;
  assign psum_nxt  = psum_r + SUM_W'(frc_data.pitch_force) - SUM_W'(pold);
  assign ysum_nxt  = ysum_r + SUM_W'(frc_data.yaw_force) - SUM_W'(yold);

  always_ff @(posedge clk) begin
    if (take) begin
      pwin_r[slot_r] <= frc_data.pitch_force;
      ywin_r[slot_r] <= frc_data.yaw_force;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psum_r <= '0;
      ysum_r <= '0;
      slot_r <= '0;
      fill_r <= '0;
      v4_r   <= 1'b0;
    end else if (rdy4) begin
      v4_r <= take && (fill_r >= FILL_W'(2 * WINDOW));
      if (frc_valid) begin
        psum_r <= psum_nxt;
        ysum_r <= ysum_nxt;
        slot_r <= (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + SLOT_W'(1);
        if (fill_r != FILL_W'(2 * WINDOW + 1)) fill_r <= fill_r + FILL_W'(1);
      end
    end
  end

  assign sum_valid          = v4_r;
  assign sum_data.pitch_sum = psum_r;
  assign sum_data.yaw_sum   = ysum_r;

endmodule

// File: src/tcmd_decide.sv
module tcmd_decide import tcmd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      sum_valid,
  output logic      sum_ready,
  input  sum_t      sum_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic                     out_valid_r;
  out_item_t                out_r, out_nxt;
  logic                     pitch_contact_r, yaw_contact_r;
  logic                     pflag_nxt, yflag_nxt;
  logic                     rdy5;
  logic signed [DIFF_W-1:0] pd, yd;
  logic [DIFF_W-1:0]        pad, yad, pth, yth;

  assign rdy5      = !out_valid_r || out_ready;
  assign sum_ready = rdy5;

  // The mean is compared without dividing: sum against bias and threshold times WINDOW.
  assign pd  = DIFF_W'(sum_data.pitch_sum) - DIFF_W'(cfg.pitch_bias_w);
  assign yd  = DIFF_W'(sum_data.yaw_sum) - DIFF_W'(cfg.yaw_bias_w);
  assign pad = pd[DIFF_W-1] ? -pd : pd;
  assign yad = yd[DIFF_W-1] ? -yd : yd;
  assign pth = DIFF_W'(cfg.pitch_thr_w);
  assign yth = DIFF_W'(cfg.yaw_thr_w);

  // Equality with the threshold keeps the flag as it was.
  assign pflag_nxt = pitch_contact_r ? !(pad < pth) : (pad > pth);
  assign yflag_nxt = yaw_contact_r ? !(yad < yth) : (yad > yth);

  always_comb begin
    out_nxt.speed_forward = '0;
    out_nxt.speed_turn    = '0;
    if (pflag_nxt) begin
      out_nxt.speed_forward = (pd > 0) ? 14'(cfg.step) : -14'(cfg.step);
    end
    if (yflag_nxt) begin
      out_nxt.speed_turn = (yd > 0) ? 16'(cfg.step3) : -16'(cfg.step3);
    end
    out_nxt.contact_pitch = pflag_nxt;
    out_nxt.contact_yaw   = yflag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r     <= 1'b0;
      pitch_contact_r <= 1'b0;
      yaw_contact_r   <= 1'b0;
    end else if (rdy5) begin
      out_valid_r <= sum_valid;
      if (sum_valid) begin
        pitch_contact_r <= pflag_nxt;
        yaw_contact_r   <= yflag_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && sum_valid) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: src/torque_contact_motion_detector_unit.sv
// Channel  Handshake            Payload      Role
// in       in_valid, in_ready   in_data      joint torque item
// out      out_valid, out_ready out_data     speed and contact result item
// cfg      cfg_we               cfg_addr,    register write, no wait
//                               cfg_wdata
// One item per cycle while out_ready is high. An accepted arm item reaches out_valid
// through five register stages: input, product, rounding, window sums, decision.
// The first 2*WINDOW arm items give no result; items with from_arm low are taken and dropped.
// Reset is synchronous and needs no clearing pass; unwritten window slots count as zero.
// Each stage holds while the next one is full and stalled, so in_ready falls only when
// all five stages hold items and out_ready is low.
`include "torque_contact_motion_detector_unit_assert.svh"

module torque_contact_motion_detector_unit import tcmd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t   cfg;
  logic   frc_valid, frc_ready;
  force_t frc_data;
  logic   sum_valid, sum_ready;
  sum_t   sum_data;

  tcmd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tcmd_force u_force (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .frc_valid (frc_valid),
    .frc_ready (frc_ready),
    .frc_data  (frc_data)
  );

  tcmd_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .frc_valid (frc_valid),
    .frc_ready (frc_ready),
    .frc_data  (frc_data),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum_data  (sum_data)
  );

  tcmd_decide u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum_data  (sum_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A nonzero speed needs the matching contact flag.
  `TCMD_ASSERT_NOW(a_fwd_needs_contact, clk, rst_n, out_valid && out_data.speed_forward != 0, out_data.contact_pitch, "forward speed without pitch contact")
  `TCMD_ASSERT_NOW(a_turn_needs_contact, clk, rst_n, out_valid && out_data.speed_turn != 0, out_data.contact_yaw, "turn speed without yaw contact")
  // Back-pressure reaches the input only when the result stage itself is stalled.
  `TCMD_ASSERT_NOW(a_stall_source, clk, rst_n, !in_ready, out_valid && !out_ready, "input stalled while output free")
  // The window stage is the only path to a result.
  `TCMD_ASSERT_NEXT(a_result_source, clk, rst_n, !sum_valid && !out_valid, !out_valid, "result without window stage item")

endmodule
